FILE: rtl/core/scmc_pkg.sv
`timescale 1ns / 1ps

package scmc_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int KEPT_W     = 7;
    localparam int TM_W       = SAMPLE_W + 1;
    localparam int P_W        = SAMPLE_W + IDX_W;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int Q_W        = SQ_W + IDX_W;
    localparam int HH_W       = 2 * CNT_W;
    localparam int DSQ_W      = 2 * TM_W;
    localparam int WIDE_W     = 64;
    localparam int MB_W       = 32;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INS_STEP,
        ST_INS_CMP,
        ST_CHK_LAST,
        ST_SUM_RD,
        ST_SUM_SQ,
        ST_SUM_ADD,
        ST_MED_A,
        ST_MED_B,
        ST_MED_C,
        ST_HQ_START,
        ST_HQ_RUN,
        ST_PP_START,
        ST_PP_RUN,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_SQ,
        ST_SH_RUN,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_OVF,
        OP_INS_READ,
        OP_INS_SHIFT,
        OP_INS_PUT,
        OP_END_SETUP,
        OP_SUM_READ,
        OP_SUM_SQ,
        OP_SUM_ADD,
        OP_MED_A,
        OP_MED_B,
        OP_MED_C,
        OP_MUL_HQ,
        OP_MUL_PP,
        OP_MUL_STEP,
        OP_SAVE_T1,
        OP_SAVE_VAR,
        OP_SCAN_READ,
        OP_SCAN_NEXT,
        OP_SCAN_DIFF,
        OP_SCAN_SQ,
        OP_SCAN_HIT,
        OP_SCAN_END,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic v_zero;
        logic full;
        logic idx_zero;
        logic shift_up;
        logic last;
        logic cnt_zero;
        logic half_ge2;
        logic sum_done;
        logic mul_done;
        logic scan_end;
        logic d_neg;
        logic hit;
        logic out_busy;
    } status_t;

endpackage

FILE: rtl/core/scmc_in_if.sv
`timescale 1ns / 1ps

interface scmc_in_if;
    logic                          valid;
    logic                          ready;
    logic [scmc_pkg::SAMPLE_W-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

FILE: rtl/core/scmc_out_if.sv
`timescale 1ns / 1ps

interface scmc_out_if;
    logic                          valid;
    logic                          ready;
    logic [scmc_pkg::SAMPLE_W-1:0] combined;
    logic [scmc_pkg::KEPT_W-1:0]   kept_count;
    logic                          empty_stack;
    logic                          overflowed;

    modport source (output valid, output combined, output kept_count,
                    output empty_stack, output overflowed, input ready);
    modport sink (input valid, input combined, input kept_count,
                  input empty_stack, input overflowed, output ready);
endinterface

FILE: rtl/core/sigma_clipped_median_combine_top.sv
`timescale 1ns / 1ps

// sigma-clipped median of one pixel stack
// stack channel: one sample word per frame, last_sample marks the final word;
// zero samples are skipped, the rest are insertion-sorted into a 64-entry ram
// result channel: one word per stack (combined, kept_count, empty_stack,
// overflowed), none for words without last_sample
// a sample that finds the ram full is dropped and sets overflowed; a kept
// sample is compared with the filled entries from the top down, each larger
// one moving up one place, the most when the stack arrives in falling order
// end of stack: lower-half sums are read one entry at a time, two shift-add
// multiplies take one multiplier bit per cycle (up to 6 and 21 bits), the
// scan skips the multiply for entries below the median and runs one for each
// entry at or above it, and the final median is read back, all serialised on
// the single ram read port and the shared shift-add multiplier
// the result sits in an output register; the next stack is taken while it
// waits, and a stalled receiver only holds the block once the next stack's
// result is ready
// reset clears the fill count, the drop flag and the output valid; the ram
// needs no clearing since only filled entries are read

module sigma_clipped_median_combine_top (
    input logic        clk,
    input logic        rst_n,
    scmc_in_if.sink    stack,
    scmc_out_if.source result
);

    scmc_pkg::op_t     op;
    scmc_pkg::status_t status;

    scmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stack.valid),
        .in_ready (stack.ready),
        .status   (status),
        .op       (op)
    );

    scmc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .sample      (stack.sample),
        .last_sample (stack.last_sample),
        .out_ready   (result.ready),
        .status      (status),
        .out_valid   (result.valid),
        .combined    (result.combined),
        .kept_count  (result.kept_count),
        .empty_stack (result.empty_stack),
        .overflowed  (result.overflowed)
    );

endmodule

FILE: rtl/core/scmc_ram.sv
`timescale 1ns / 1ps

module scmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/scmc_ctrl.sv
`timescale 1ns / 1ps

module scmc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  scmc_pkg::status_t status,
    output scmc_pkg::op_t     op
);

    scmc_pkg::state_t state_reg, state_next;
    logic             final_reg, final_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scmc_pkg::ST_IDLE;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        op         = scmc_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            scmc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = scmc_pkg::OP_LOAD;
                    state_next = scmc_pkg::ST_INS_STEP;
                end
            end
            scmc_pkg::ST_INS_STEP:
            begin
                if (status.v_zero)
                begin
                    state_next = scmc_pkg::ST_CHK_LAST;
                end
                else if (status.full)
                begin
                    op         = scmc_pkg::OP_SET_OVF;
                    state_next = scmc_pkg::ST_CHK_LAST;
                end
                else if (status.idx_zero)
                begin
                    op         = scmc_pkg::OP_INS_PUT;
                    state_next = scmc_pkg::ST_CHK_LAST;
                end
                else
                begin
                    op         = scmc_pkg::OP_INS_READ;
                    state_next = scmc_pkg::ST_INS_CMP;
                end
            end
            scmc_pkg::ST_INS_CMP:
            begin
                if (status.shift_up)
                begin
                    op         = scmc_pkg::OP_INS_SHIFT;
                    state_next = scmc_pkg::ST_INS_STEP;
                end
                else
                begin
                    op         = scmc_pkg::OP_INS_PUT;
                    state_next = scmc_pkg::ST_CHK_LAST;
                end
            end
            scmc_pkg::ST_CHK_LAST:
            begin
                if (!status.last)
                begin
                    state_next = scmc_pkg::ST_IDLE;
                end
                else
                begin
                    op = scmc_pkg::OP_END_SETUP;
                    if (status.cnt_zero)
                    begin
                        state_next = scmc_pkg::ST_FINISH;
                    end
                    else if (status.half_ge2)
                    begin
                        final_next = 1'b0;
                        state_next = scmc_pkg::ST_SUM_RD;
                    end
                    else
                    begin
                        final_next = 1'b1;
                        state_next = scmc_pkg::ST_MED_A;
                    end
                end
            end
            scmc_pkg::ST_SUM_RD:
            begin
                op         = scmc_pkg::OP_SUM_READ;
                state_next = scmc_pkg::ST_SUM_SQ;
            end
            scmc_pkg::ST_SUM_SQ:
            begin
                op         = scmc_pkg::OP_SUM_SQ;
                state_next = scmc_pkg::ST_SUM_ADD;
            end
            scmc_pkg::ST_SUM_ADD:
            begin
                op         = scmc_pkg::OP_SUM_ADD;
                state_next = status.sum_done ? scmc_pkg::ST_MED_A : scmc_pkg::ST_SUM_RD;
            end
            scmc_pkg::ST_MED_A:
            begin
                op         = scmc_pkg::OP_MED_A;
                state_next = scmc_pkg::ST_MED_B;
            end
            scmc_pkg::ST_MED_B:
            begin
                op         = scmc_pkg::OP_MED_B;
                state_next = scmc_pkg::ST_MED_C;
            end
            scmc_pkg::ST_MED_C:
            begin
                op         = scmc_pkg::OP_MED_C;
                state_next = final_reg ? scmc_pkg::ST_FINISH : scmc_pkg::ST_HQ_START;
            end
            scmc_pkg::ST_HQ_START:
            begin
                op         = scmc_pkg::OP_MUL_HQ;
                state_next = scmc_pkg::ST_HQ_RUN;
            end
            scmc_pkg::ST_HQ_RUN:
            begin
                if (status.mul_done)
                begin
                    op         = scmc_pkg::OP_SAVE_T1;
                    state_next = scmc_pkg::ST_PP_START;
                end
                else
                begin
                    op = scmc_pkg::OP_MUL_STEP;
                end
            end
            scmc_pkg::ST_PP_START:
            begin
                op         = scmc_pkg::OP_MUL_PP;
                state_next = scmc_pkg::ST_PP_RUN;
            end
            scmc_pkg::ST_PP_RUN:
            begin
                if (status.mul_done)
                begin
                    op         = scmc_pkg::OP_SAVE_VAR;
                    state_next = scmc_pkg::ST_SCAN_RD;
                end
                else
                begin
                    op = scmc_pkg::OP_MUL_STEP;
                end
            end
            scmc_pkg::ST_SCAN_RD:
            begin
                if (status.scan_end)
                begin
                    op         = scmc_pkg::OP_SCAN_END;
                    final_next = 1'b1;
                    state_next = scmc_pkg::ST_MED_A;
                end
                else
                begin
                    op         = scmc_pkg::OP_SCAN_READ;
                    state_next = scmc_pkg::ST_SCAN_CHK;
                end
            end
            scmc_pkg::ST_SCAN_CHK:
            begin
                if (status.d_neg)
                begin
                    op         = scmc_pkg::OP_SCAN_NEXT;
                    state_next = scmc_pkg::ST_SCAN_RD;
                end
                else
                begin
                    op         = scmc_pkg::OP_SCAN_DIFF;
                    state_next = scmc_pkg::ST_SCAN_SQ;
                end
            end
            scmc_pkg::ST_SCAN_SQ:
            begin
                op         = scmc_pkg::OP_SCAN_SQ;
                state_next = scmc_pkg::ST_SH_RUN;
            end
            scmc_pkg::ST_SH_RUN:
            begin
                if (!status.mul_done)
                begin
                    op = scmc_pkg::OP_MUL_STEP;
                end
                else if (status.hit)
                begin
                    op         = scmc_pkg::OP_SCAN_HIT;
                    final_next = 1'b1;
                    // nothing below the bound: report the lower-half median
                    state_next = status.idx_zero ? scmc_pkg::ST_FINISH : scmc_pkg::ST_MED_A;
                end
                else
                begin
                    op         = scmc_pkg::OP_SCAN_NEXT;
                    state_next = scmc_pkg::ST_SCAN_RD;
                end
            end
            scmc_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    op         = scmc_pkg::OP_FINISH;
                    state_next = scmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scmc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/scmc_dp.sv
`timescale 1ns / 1ps

module scmc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scmc_pkg::op_t                 op,
    input  logic [scmc_pkg::SAMPLE_W-1:0] sample,
    input  logic                          last_sample,
    input  logic                          out_ready,
    output scmc_pkg::status_t             status,
    output logic                          out_valid,
    output logic [scmc_pkg::SAMPLE_W-1:0] combined,
    output logic [scmc_pkg::KEPT_W-1:0]   kept_count,
    output logic                          empty_stack,
    output logic                          overflowed
);

    localparam int CW = scmc_pkg::CNT_W;
    localparam int IW = scmc_pkg::IDX_W;

    logic [CW-1:0]                    cnt_reg, idx_reg, h_reg, k_reg, medc_reg;
    logic                             ovf_reg, last_reg;
    logic [scmc_pkg::SAMPLE_W-1:0]    v_reg, med_reg;
    logic [scmc_pkg::P_W-1:0]         p_reg;
    logic [scmc_pkg::Q_W-1:0]         q_reg;
    logic [scmc_pkg::SQ_W-1:0]        sq_reg;
    logic [scmc_pkg::TM_W-1:0]        tm_reg, d_reg;
    logic [scmc_pkg::HH_W-1:0]        hh_reg;
    logic [scmc_pkg::WIDE_W-1:0]      ma_reg, acc_reg, t1_reg, var4_reg;
    logic [scmc_pkg::MB_W-1:0]        mb_reg;

    logic                             out_valid_reg, out_empty_reg, out_ovf_reg;
    logic [scmc_pkg::SAMPLE_W-1:0]    out_comb_reg;
    logic [scmc_pkg::KEPT_W-1:0]      out_kept_reg;

    logic                             we;
    logic [IW-1:0]                    waddr, raddr;
    logic [scmc_pkg::SAMPLE_W-1:0]    wdata, rdata;
    logic [CW-1:0]                    h_w, med_half;
    logic [scmc_pkg::TM_W:0]          diff, tm_plus;
    logic [scmc_pkg::DSQ_W-1:0]       dsq;

    scmc_ram #(
        .WIDTH (scmc_pkg::SAMPLE_W),
        .DEPTH (scmc_pkg::MAX_FRAMES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign h_w      = cnt_reg >> 1;
    assign med_half = medc_reg >> 1;
    // twice the sample minus twice the median, one extra bit for the sign
    assign diff     = {1'b0, rdata, 1'b0} - {1'b0, tm_reg};
    assign tm_plus  = {1'b0, tm_reg} + {{scmc_pkg::TM_W{1'b0}}, 1'b1};
    assign dsq      = scmc_pkg::DSQ_W'(d_reg) * scmc_pkg::DSQ_W'(d_reg);

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[IW-1:0];
        wdata = v_reg;
        raddr = idx_reg[IW-1:0];
        case (op)
            scmc_pkg::OP_INS_READ:  raddr = IW'(idx_reg - CW'(1));
            scmc_pkg::OP_INS_SHIFT:
            begin
                we    = 1'b1;
                wdata = rdata;
            end
            scmc_pkg::OP_INS_PUT:   we = 1'b1;
            scmc_pkg::OP_MED_A:
            begin
                raddr = medc_reg[0] ? med_half[IW-1:0] : IW'(med_half - CW'(1));
            end
            scmc_pkg::OP_MED_B:     raddr = med_half[IW-1:0];
            default:                we = 1'b0;
        endcase
    end

    always_comb
    begin
        status.v_zero   = (v_reg == '0);
        status.full     = (cnt_reg == CW'(scmc_pkg::MAX_FRAMES));
        status.idx_zero = (idx_reg == '0);
        status.shift_up = (rdata > v_reg);
        status.last     = last_reg;
        status.cnt_zero = (cnt_reg == '0);
        status.half_ge2 = (h_w >= CW'(2));
        status.sum_done = (idx_reg == h_reg);
        status.mul_done = (mb_reg == '0);
        status.scan_end = (idx_reg == cnt_reg);
        status.d_neg    = diff[scmc_pkg::TM_W];
        status.hit      = (acc_reg >= var4_reg);
        status.out_busy = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                scmc_pkg::OP_SET_OVF: ovf_reg <= 1'b1;
                scmc_pkg::OP_INS_PUT: cnt_reg <= cnt_reg + CW'(1);
                scmc_pkg::OP_FINISH:
                begin
                    cnt_reg       <= '0;
                    ovf_reg       <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            scmc_pkg::OP_LOAD:
            begin
                v_reg    <= sample;
                last_reg <= last_sample;
                idx_reg  <= cnt_reg;
            end
            scmc_pkg::OP_INS_SHIFT: idx_reg <= idx_reg - CW'(1);
            scmc_pkg::OP_END_SETUP:
            begin
                h_reg    <= h_w;
                k_reg    <= cnt_reg;
                medc_reg <= (h_w >= CW'(2)) ? h_w : cnt_reg;
                hh_reg   <= scmc_pkg::HH_W'(h_w) * scmc_pkg::HH_W'(h_w - CW'(1));
                p_reg    <= '0;
                q_reg    <= '0;
                idx_reg  <= '0;
            end
            scmc_pkg::OP_SUM_SQ:
            begin
                p_reg   <= p_reg + scmc_pkg::P_W'(rdata);
                sq_reg  <= scmc_pkg::SQ_W'(rdata) * scmc_pkg::SQ_W'(rdata);
                idx_reg <= idx_reg + CW'(1);
            end
            scmc_pkg::OP_SUM_ADD:   q_reg <= q_reg + scmc_pkg::Q_W'(sq_reg);
            scmc_pkg::OP_MED_B:     med_reg <= rdata;
            scmc_pkg::OP_MED_C:
            begin
                tm_reg <= medc_reg[0] ? {med_reg, 1'b0}
                                      : scmc_pkg::TM_W'(med_reg) + scmc_pkg::TM_W'(rdata);
            end
            scmc_pkg::OP_MUL_HQ:
            begin
                ma_reg  <= scmc_pkg::WIDE_W'(q_reg);
                mb_reg  <= scmc_pkg::MB_W'(h_reg);
                acc_reg <= '0;
            end
            scmc_pkg::OP_MUL_PP:
            begin
                ma_reg  <= scmc_pkg::WIDE_W'(p_reg);
                mb_reg  <= scmc_pkg::MB_W'(p_reg);
                acc_reg <= '0;
            end
            scmc_pkg::OP_MUL_STEP:
            begin
                // shift-add, one multiplier bit per cycle
                if (mb_reg[0])
                begin
                    acc_reg <= acc_reg + ma_reg;
                end
                ma_reg <= ma_reg << 1;
                mb_reg <= mb_reg >> 1;
            end
            scmc_pkg::OP_SAVE_T1:   t1_reg <= acc_reg;
            scmc_pkg::OP_SAVE_VAR:
            begin
                var4_reg <= (t1_reg - acc_reg) << 2;
                idx_reg  <= '0;
            end
            scmc_pkg::OP_SCAN_NEXT: idx_reg <= idx_reg + CW'(1);
            scmc_pkg::OP_SCAN_DIFF: d_reg <= diff[scmc_pkg::TM_W-1:0];
            scmc_pkg::OP_SCAN_SQ:
            begin
                ma_reg  <= scmc_pkg::WIDE_W'(dsq);
                mb_reg  <= scmc_pkg::MB_W'(hh_reg);
                acc_reg <= '0;
            end
            scmc_pkg::OP_SCAN_HIT, scmc_pkg::OP_SCAN_END:
            begin
                k_reg    <= idx_reg;
                medc_reg <= idx_reg;
            end
            scmc_pkg::OP_FINISH:
            begin
                out_comb_reg  <= (cnt_reg == '0) ? '0 : tm_plus[scmc_pkg::TM_W-1:1];
                out_kept_reg  <= scmc_pkg::KEPT_W'(k_reg);
                out_empty_reg <= (cnt_reg == '0);
                out_ovf_reg   <= ovf_reg;
            end
            default:
            begin
                v_reg <= v_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign combined    = out_comb_reg;
    assign kept_count  = out_kept_reg;
    assign empty_stack = out_empty_reg;
    assign overflowed  = out_ovf_reg;

endmodule

FILE: sim/scmc_tb_if.sv
`timescale 1ns / 1ps

// the block's channel interfaces live with the rtl; this file only holds the
// result item type the bench passes from its receiver to the scoreboard

package scmc_tb_pkg;

    typedef struct packed {
        logic [15:0] combined;
        logic [6:0]  kept_count;
        logic        empty_stack;
        logic        overflowed;
    } stack_result_t;

endpackage

FILE: sim/sigma_clipped_median_combine_top_tb.sv
`timescale 1ns / 1ps

module sigma_clipped_median_combine_top_tb;

    class stack_scoreboard;
        logic [15:0]                sorted_vals [scmc_pkg::MAX_FRAMES];
        int                         fill;
        bit                         dropped;
        scmc_tb_pkg::stack_result_t pending [$];
        int                         mismatches;

        function new();
            fill = 0;
            dropped = 0;
            mismatches = 0;
        endfunction

        function longint unsigned twice_med(int c);
            if (c % 2)
                return 2 * longint'(sorted_vals[c / 2]);
            return longint'(sorted_vals[c / 2 - 1]) + longint'(sorted_vals[c / 2]);
        endfunction

        function void note_sample(logic [15:0] v, logic last);
            scmc_tb_pkg::stack_result_t r;
            int i, h, k;
            longint unsigned p, q, var4, hh, ud;
            longint m2, d2;
            if (v != 0)
            begin
                if (fill >= scmc_pkg::MAX_FRAMES)
                    dropped = 1;
                else
                begin
                    i = fill;
                    while (i > 0 && sorted_vals[i - 1] > v)
                    begin
                        sorted_vals[i] = sorted_vals[i - 1];
                        i--;
                    end
                    sorted_vals[i] = v;
                    fill++;
                end
            end
            if (!last)
                return;
            r = '0;
            r.overflowed = dropped;
            if (fill == 0)
                r.empty_stack = 1;
            else
            begin
                h = fill / 2;
                k = fill;
                if (h >= 2)
                begin
                    p = 0;
                    q = 0;
                    m2 = longint'(twice_med(h));
                    for (i = 0; i < h; i++)
                    begin
                        p += sorted_vals[i];
                        q += longint'(sorted_vals[i]) * sorted_vals[i];
                    end
                    var4 = 4 * (h * q - p * p);
                    hh = h * (h - 1);
                    for (i = 0; i < fill; i++)
                    begin
                        d2 = 2 * longint'(sorted_vals[i]) - m2;
                        if (d2 >= 0)
                        begin
                            ud = d2;
                            if (ud * ud * hh >= var4)
                                break;
                        end
                    end
                    k = i;
                    if (k == 0)
                        r.combined = 16'((m2 + 1) >> 1);
                end
                if (k > 0)
                    r.combined = 16'((twice_med(k) + 1) >> 1);
                r.kept_count = 7'(k);
            end
            pending.push_back(r);
            fill = 0;
            dropped = 0;
        endfunction

        function void check_result(scmc_tb_pkg::stack_result_t got);
            scmc_tb_pkg::stack_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    scmc_in_if  stack_ch ();
    scmc_out_if result_ch ();
    stack_scoreboard sb;

    sigma_clipped_median_combine_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stack  (stack_ch.sink),
        .result (result_ch.source)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver side: ready changes on the falling edge, words taken on the rising edge
    initial
    begin
        result_ch.ready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result({result_ch.combined, result_ch.kept_count,
                                 result_ch.empty_stack, result_ch.overflowed});
            @(negedge clk);
            result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(logic [15:0] v, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            stack_ch.valid = 0;
            @(negedge clk);
        end
        stack_ch.valid = 1;
        stack_ch.sample = v;
        stack_ch.last_sample = last;
        do
            @(posedge clk);
        while (!stack_ch.ready);
        sb.note_sample(v, last);
        @(negedge clk);
        stack_ch.valid = 0;
    endtask

    task automatic send_stack(int n, int style);
        logic [15:0] base, v;
        int i;
        base = 16'($urandom_range(1, 60000));
        for (i = 0; i < n; i++)
        begin
            case (style)
                0: v = 16'($urandom);
                1: v = 16'(base + $urandom_range(0, 40));
                2: v = ($urandom_range(99) < 20) ? 16'd0 : 16'(base + $urandom_range(0, 400));
                3: v = ($urandom_range(99) < 25) ? 16'(base + 5000 + $urandom_range(0, 3000))
                                                 : 16'(base + $urandom_range(0, 50));
                default: v = 16'(16'hFFFF - i);
            endcase
            send_word(v, i == n - 1);
        end
    endtask

    task automatic random_phase(int words);
        int sent, n;
        sent = 0;
        while (sent < words)
        begin
            n = ($urandom_range(99) < 5) ? $urandom_range(60, 70) : $urandom_range(1, 12);
            send_stack(n, $urandom_range(0, 4));
            sent += n;
        end
    endtask

    initial
    begin
        int i;
        sb = new();
        rst_n = 0;
        stack_ch.valid = 0;
        stack_ch.sample = 0;
        stack_ch.last_sample = 0;
        send_idle_pct = 17;
        recv_idle_pct = 71;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty stacks, single samples, extremes, tie cases, an overflowing stack
        send_word(16'd0, 1);
        send_word(16'd0, 0);
        send_word(16'd0, 1);
        send_word(16'hFFFF, 1);
        send_word(16'd1, 0);
        send_word(16'hFFFF, 1);
        send_word(16'd3, 0);
        send_word(16'd1, 0);
        send_word(16'd2, 1);
        for (i = 0; i < 4; i++)
            send_word(16'd7, i == 3);
        send_word(16'd1, 0);
        send_word(16'd2, 0);
        send_word(16'd3, 0);
        send_word(16'd4, 0);
        send_word(16'hFFFF, 1);
        send_stack(70, 4);
        send_stack(6, 3);

        random_phase(500);
        send_idle_pct = 71;
        recv_idle_pct = 17;
        random_phase(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(500);

        i = 0;
        while (sb.pending.size() != 0 && i < 200000)
        begin
            @(posedge clk);
            i++;
        end
        repeat (500) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: files.f
rtl/core/scmc_pkg.sv
rtl/core/scmc_in_if.sv
rtl/core/scmc_out_if.sv
rtl/core/scmc_ram.sv
rtl/core/scmc_ctrl.sv
rtl/core/scmc_dp.sv
rtl/core/sigma_clipped_median_combine_top.sv
sim/scmc_tb_if.sv
sim/sigma_clipped_median_combine_top_tb.sv
